FILE: src/tomp_pkg.sv
// shared types and option constants for the tcp option mss parser
`default_nettype none
package tomp_pkg;

  // option kinds of interest
  localparam logic [7:0] KIND_END    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  // length byte values
  localparam logic [7:0] LEN_MIN     = 8'd2;
  localparam logic [7:0] MSS_OPT_LEN = 8'd4;

  // one input beat, split into its fields
  typedef struct packed {
    logic [7:0]  opt_byte;
    logic [15:0] current_mss;
    logic        first_byte;
    logic        last_byte;
  } tomp_beat_t;

  // one result item
  typedef struct packed {
    logic [15:0] mss_out;
    logic        mss_option_taken;
    logic        malformed;
  } tomp_result_t;

endpackage
`default_nettype wire

FILE: src/tomp_parse_core.sv
// option parse state and per-byte next-state logic
`default_nettype none
module tomp_parse_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire tomp_pkg::tomp_beat_t  beat_i,
  output tomp_pkg::tomp_result_t     result_o
);
  import tomp_pkg::*;

  typedef enum logic [2:0] {
    PH_KIND    = 3'd0,
    PH_LEN_MSS = 3'd1,
    PH_LEN_OTH = 3'd2,
    PH_MSS_HI  = 3'd3,
    PH_MSS_LO  = 3'd4,
    PH_SKIP    = 3'd5,
    PH_STOP    = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d, phase_s;
  logic [7:0]  skip_q, skip_d, skip_s;
  logic [7:0]  hi_q, hi_d, hi_s;
  logic [15:0] mss_q, mss_d, mss_s;
  logic        taken_q, taken_d, taken_s;
  logic        err_q, err_d, err_s;
  logic [7:0]  b;
  logic [15:0] mss_val;

  assign b       = beat_i.opt_byte;
  assign mss_val = {hi_s, b};

  always_comb begin
    // a first byte restarts the parse from a clean state
    if (beat_i.first_byte) begin
      phase_s = PH_KIND;
      skip_s  = '0;
      hi_s    = '0;
      mss_s   = beat_i.current_mss;
      taken_s = 1'b0;
      err_s   = 1'b0;
    end else begin
      phase_s = phase_q;
      skip_s  = skip_q;
      hi_s    = hi_q;
      mss_s   = mss_q;
      taken_s = taken_q;
      err_s   = err_q;
    end

    phase_d = phase_s;
    skip_d  = skip_s;
    hi_d    = hi_s;
    mss_d   = mss_s;
    taken_d = taken_s;
    err_d   = err_s;

    // consume this byte
    case (phase_s)
      PH_KIND: begin
        if (b == KIND_END) begin
          phase_d = PH_STOP;
        end else if (b == KIND_NOP) begin
          phase_d = PH_KIND;
        end else if (b == KIND_MSS) begin
          phase_d = PH_LEN_MSS;
        end else begin
          phase_d = PH_LEN_OTH;
        end
      end
      PH_LEN_MSS, PH_LEN_OTH: begin
        if (b < LEN_MIN) begin
          err_d   = 1'b1;
          phase_d = PH_STOP;
        end else if (b == LEN_MIN) begin
          phase_d = PH_KIND;
        end else if (phase_s == PH_LEN_MSS && b == MSS_OPT_LEN) begin
          phase_d = PH_MSS_HI;
        end else begin
          skip_d  = b - LEN_MIN;
          phase_d = PH_SKIP;
        end
      end
      PH_MSS_HI: begin
        hi_d    = b;
        phase_d = PH_MSS_LO;
      end
      PH_MSS_LO: begin
        if (mss_val < mss_s) begin
          mss_d = mss_val;
        end
        taken_d = 1'b1;
        phase_d = PH_KIND;
      end
      PH_SKIP: begin
        skip_d = skip_s - 8'd1;
        if (skip_d == 8'd0) begin
          phase_d = PH_KIND;
        end
      end
      default: begin
        phase_d = PH_STOP;
      end
    endcase

    // end of area: an option still open is malformed, then stop
    if (beat_i.last_byte) begin
      if (phase_d != PH_KIND && phase_d != PH_STOP) begin
        err_d = 1'b1;
      end
      phase_d = PH_STOP;
    end
  end

  assign result_o = '{mss_out: mss_d, mss_option_taken: taken_d, malformed: err_d};

  // parse state, updated once per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_KIND;
      skip_q  <= '0;
      hi_q    <= '0;
      mss_q   <= '0;
      taken_q <= 1'b0;
      err_q   <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      hi_q    <= hi_d;
      mss_q   <= mss_d;
      taken_q <= taken_d;
      err_q   <= err_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/tomp_out_reg.sv
// result register on the master side
`default_nettype none
module tomp_out_reg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire tomp_pkg::tomp_result_t result_i,
  input  wire logic                  ready_i,
  output logic                       valid_o,
  output tomp_pkg::tomp_result_t     result_o
);
  import tomp_pkg::*;

  logic         valid_q;
  tomp_result_t result_q;

  // valid flag: set on load, cleared when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
`default_nettype wire

FILE: src/tcp_option_mss_parser.sv
// tcp option mss parser top level: input register, parse core, result register
// two register stages: a last byte's beat is registered in the input register, then its result in the result register
// throughput: one option byte per cycle while no waiting result holds the input register
// a waiting result holds the input register, so the slave side stalls after one more beat
// reset: asynchronous active low; parse restarts expecting a kind with mss zero
// reset empties both the input and the result register
`default_nettype none
module tcp_option_mss_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // opt_byte[7:0], current_mss[23:8]
  input  wire logic [0:0]  s_axis_tuser_i,  // first_byte[0]
  input  wire logic        s_axis_tlast_i,  // last_byte
  // master side
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o   // mss_out[15:0], mss_option_taken[16],
                                            // malformed[17], zero[23:18]
);
  import tomp_pkg::*;

  logic         in_valid_q;
  tomp_beat_t   in_q;
  logic         adv;
  tomp_result_t core_res;
  tomp_result_t out_res;

  // a held beat moves on when the result register can take it
  assign adv             = in_valid_q && (!m_axis_tvalid_o || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q <= '{opt_byte:    s_axis_tdata_i[7:0],
                current_mss: s_axis_tdata_i[23:8],
                first_byte:  s_axis_tuser_i[0],
                last_byte:   s_axis_tlast_i};
    end
  end

  tomp_parse_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .beat_i   (in_q),
    .result_o (core_res)
  );

  tomp_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv && in_q.last_byte),
    .result_i (core_res),
    .ready_i  (m_axis_tready_i),
    .valid_o  (m_axis_tvalid_o),
    .result_o (out_res)
  );

  assign m_axis_tdata_o = {6'b0, out_res.malformed, out_res.mss_option_taken, out_res.mss_out};

  // an empty input register always takes a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready_o)
    else $error("input register empty but not ready");

  // a last byte that moves on produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.last_byte) |=> m_axis_tvalid_o)
    else $error("last byte gave no result");

  // a non-last byte moving on while the output drains leaves no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !in_q.last_byte && m_axis_tready_i) |=> !m_axis_tvalid_o)
    else $error("result invented for a non-last byte");

endmodule
`default_nettype wire
